// ----- design/combination_rank_to_bitmask_macros.svh -----
`ifndef COMBINATION_RANK_TO_BITMASK_MACROS_SVH
`define COMBINATION_RANK_TO_BITMASK_MACROS_SVH

// same-cycle implication under the block reset
`define CRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the block reset
`define CRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/crb_pkg.sv -----
package crb_pkg;

	localparam int RANK_W       = 63;
	localparam int MASK_W       = 63;
	localparam int CFG_W        = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int DATA_W       = 64;
	localparam int REM_W        = 6;
	localparam int MAX_R        = (1 << REM_W) - 1;
	localparam int MAX_BITS_DEF = 63;

	localparam logic [CFG_W-1:0] BITS_IN_USE_RST = 6'd63;
	localparam logic [CFG_W-1:0] ONES_COUNT_RST  = 6'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BITS_IN_USE = 2'd0,
		REG_ONES_COUNT  = 2'd1
	} cfg_reg_t;

	typedef logic [MAX_R:0][RANK_W-1:0] binom_row_t;

	// row n of the Pascal triangle, C(n, r) for r = 0 .. MAX_R
	function automatic binom_row_t pascal_row(input int unsigned n);
		binom_row_t row;
		binom_row_t nxt;
		row    = '0;
		row[0] = RANK_W'(1);
		for (int unsigned i = 1; i <= n; i++) begin
			nxt = row;
			for (int r = 1; r <= MAX_R; r++) begin
				nxt[r] = row[r] + row[r-1];
			end
			row = nxt;
		end
		return row;
	endfunction

endpackage

// ----- design/combination_rank_to_bitmask.sv -----
// Combinadic unranking: turns a rank into a mask of bits_in_use bits with
// ones_count ones set.
// Input words arrive on s_tvalid/s_tready/s_tdata, one rank per word.
// Results leave on m_tvalid/m_tready/m_tdata: the mask and a flag that is
// high when the rank is at or above C(bits_in_use, ones_count).
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data:
// index 0 is bits_in_use, index 1 is ones_count; other indexes are dropped.
// Write them only while no word is in flight; cfg_ready is always high.
// The pipeline has one stage per mask position, each a 63-bit compare and
// subtract against a constant Pascal row, plus one output stage.
// Throughput is one word per cycle while the receiver does not stall.
// A stalled receiver (m_tvalid high, m_tready low) freezes the whole
// pipeline and drops s_tready; nothing is lost or repeated.
// Reset clears all valid bits and sets bits_in_use to 63, ones_count to 0.
module combination_rank_to_bitmask
	import crb_pkg::*;
#(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,   // [62:0] rank, [63] zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_W-1:0]    m_tdata,   // [62:0] mask, [63] rank_out_of_range
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] bits_in_use_q;
	logic [CFG_W-1:0] ones_count_q;
	logic [CFG_W-1:0] k_eff;
	logic             en;

	logic              vld_s  [1:MAX_BITS];
	logic [RANK_W-1:0] rank_s [1:MAX_BITS];
	logic [REM_W-1:0]  rem_s  [1:MAX_BITS];
	logic [MASK_W-1:0] mask_s [1:MAX_BITS];

	logic              out_vld_s;
	logic [MASK_W-1:0] out_mask_s;
	logic              out_oor_s;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= BITS_IN_USE_RST;
			ones_count_q  <= ONES_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BITS_IN_USE: bits_in_use_q <= cfg_data;
				REG_ONES_COUNT:  ones_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign k_eff = (bits_in_use_q > CFG_W'(MAX_BITS)) ? CFG_W'(MAX_BITS) : bits_in_use_q;

	// advance all stages together unless the output word is held
	assign en       = !out_vld_s || m_tready;
	assign s_tready = en;

	for (genvar j = 1; j <= MAX_BITS; j++) begin : g_stage
		localparam int         POS = MAX_BITS - j;
		localparam binom_row_t ROW = pascal_row(POS);

		logic              in_vld;
		logic [RANK_W-1:0] in_rank;
		logic [REM_W-1:0]  in_rem;
		logic [MASK_W-1:0] in_mask;
		logic [RANK_W-1:0] c;
		logic              act;
		logic              skip;

		if (j == 1) begin : g_first
			assign in_vld  = s_tvalid;
			assign in_rank = s_tdata[RANK_W-1:0];
			assign in_rem  = REM_W'(ones_count_q);
			assign in_mask = '0;
		end else begin : g_next
			assign in_vld  = vld_s[j-1];
			assign in_rank = rank_s[j-1];
			assign in_rem  = rem_s[j-1];
			assign in_mask = mask_s[j-1];
		end

		assign c    = ROW[in_rem - REM_W'(1)];
		assign act  = (CFG_W'(POS) < k_eff) && (in_rem != '0);
		assign skip = in_rank >= c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= in_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (act && skip) begin
					rank_s[j] <= in_rank - c;
					rem_s[j]  <= in_rem;
					mask_s[j] <= in_mask;
				end else if (act) begin
					rank_s[j] <= in_rank;
					rem_s[j]  <= in_rem - REM_W'(1);
					mask_s[j] <= in_mask | (MASK_W'(1) << POS);
				end else begin
					rank_s[j] <= in_rank;
					rem_s[j]  <= in_rem;
					mask_s[j] <= in_mask;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s <= 1'b0;
		end else if (en) begin
			out_vld_s <= vld_s[MAX_BITS];
		end
	end

	// a rank in range places every one and leaves no residue
	always_ff @(posedge clk) begin
		if (en) begin
			out_mask_s <= mask_s[MAX_BITS];
			out_oor_s  <= (rem_s[MAX_BITS] != '0) || (rank_s[MAX_BITS] != '0);
		end
	end

	assign m_tvalid = out_vld_s;
	assign m_tdata  = {out_oor_s, out_mask_s};

`include "combination_rank_to_bitmask_macros.svh"

	`CRB_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
	`CRB_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, vld_s[1], "accepted word missing from first stage")
	`CRB_ASSERT_NOW(a_mask_width, clk, arst_n, m_tvalid, (out_mask_s >> k_eff) == '0, "mask bit set above width")
	`CRB_ASSERT_NOW(a_ones_count, clk, arst_n, m_tvalid && !out_oor_s, $countones(out_mask_s) == int'(ones_count_q), "in-range mask has wrong count of ones")

endmodule
